@@ rtl/prefix_code_tree_pixel_decoder_assert.svh @@
// Assertion macros for the prefix-code tree pixel decoder checker.
`ifndef PREFIX_CODE_TREE_PIXEL_DECODER_ASSERT_SVH
`define PREFIX_CODE_TREE_PIXEL_DECODER_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define PCTPD_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pctpd: same-cycle property violated");

// next-cycle implication, sampled on clk, off during reset
`define PCTPD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pctpd: next-cycle property violated");

`endif

@@ rtl/pctpd_pkg.sv @@
// Types and constants shared by the prefix-code tree pixel decoder files.
package pctpd_pkg;

    localparam int KIND_W      = 2;
    localparam int CODE_W      = 16;
    localparam int LEN_W       = 5;
    localparam int SYM_W       = 8;
    localparam int STATUS_W    = 2;
    localparam int POS_W       = 12;
    localparam int CFG_W       = 13;
    localparam int CFG_INDEX_W = 1;

    localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_INSERT = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DECODE = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_PIXEL      = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_MISSING    = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_STORE_FULL = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_IMAGE_FULL = 2'd3;

    localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_WIDTH  = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_HEIGHT = 1'd1;

    localparam logic [CFG_W-1:0] CFG_DIM_RESET = 13'd4096;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [CODE_W-1:0] code_bits;
        logic [LEN_W-1:0]  code_length;
        logic [SYM_W-1:0]  symbol;
        logic              stream_bit;
    } in_item_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SYM_W-1:0]    color_index;
        logic [POS_W-1:0]    row;
        logic [POS_W-1:0]    column;
    } out_item_t;

endpackage

@@ rtl/prefix_code_tree_pixel_decoder.sv @@
// Prefix-code tree pixel decoder: node store, tree build and bit-serial decode.
//
// Input channel in_valid/in_stall/in_item carries clear, insert and decode items;
// output channel out_valid/out_stall/out_item carries zero or one result per item.
// Configuration: cfg_we writes cfg_data into image width (index 0) or height (1).
// The block takes one item at a time; in_stall is high while an item is at work.
// Clear and unused kinds are done at acceptance. A decode item reads the child
// node from the node memory, then tests it and forms the result,
// which shows on out_valid the cycle after. An insert starts, then per codeword
// bit either allocates a node or reads an existing node from memory and loads
// it, and last stores the symbol; an insert that finds the store full ends there.
// The root node is held in flip-flops.
// Results sit in an output register: a new item is accepted while a result
// waits, and an item whose result finds the register still stalled holds
// until it drains. Reset clears the tree to the root, the position to row 0
// column 0 and both dimensions to 4096; the node memory needs no clearing
// pass, as every node is written before it is first read.
module prefix_code_tree_pixel_decoder #(
    parameter int MAX_CODE_LENGTH = 16,
    parameter int NODE_DEPTH      = 512,
    parameter int MAX_DIMENSION   = 4096
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  pctpd_pkg::in_item_t                 in_item,
    output logic                                out_valid,
    input  logic                                out_stall,
    output pctpd_pkg::out_item_t                out_item,
    input  logic                                cfg_we,
    input  logic [pctpd_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [pctpd_pkg::CFG_W-1:0]         cfg_data
);

    localparam int IDX_W     = $clog2(NODE_DEPTH);
    localparam int USED_W    = $clog2(NODE_DEPTH + 1);
    localparam int SYM_W     = pctpd_pkg::SYM_W;
    localparam int ENT_W     = 2 * IDX_W + SYM_W;
    localparam int DIM_W     = $clog2(MAX_DIMENSION + 1);
    localparam int CFG_W     = pctpd_pkg::CFG_W;
    localparam int CMP_W     = (DIM_W > CFG_W) ? DIM_W : CFG_W;
    localparam int LEN_W     = pctpd_pkg::LEN_W;
    localparam int CODE_W    = pctpd_pkg::CODE_W;
    localparam int BIT_W     = $clog2(CODE_W);
    localparam int LEN_LIMIT = (MAX_CODE_LENGTH < CODE_W) ? MAX_CODE_LENGTH : CODE_W;
    localparam int POS_W     = pctpd_pkg::POS_W;

    typedef enum logic [3:0] {
        ST_IDLE     = 4'b0001,
        ST_INS_STEP = 4'b0010,
        ST_INS_WAIT = 4'b0100,
        ST_DEC_WAIT = 4'b1000
    } state_t;

    state_t                 state_reg, state_next;
    logic [CFG_W-1:0]       width_reg, height_reg;
    logic [IDX_W-1:0]       root_left_reg, root_left_next;
    logic [IDX_W-1:0]       root_right_reg, root_right_next;
    logic [SYM_W-1:0]       root_sym_reg, root_sym_next;
    logic [IDX_W-1:0]       cache_left_reg, cache_left_next;
    logic [IDX_W-1:0]       cache_right_reg, cache_right_next;
    logic [IDX_W-1:0]       cur_node_reg, cur_node_next;
    logic [USED_W-1:0]      used_reg, used_next;
    logic [DIM_W-1:0]       col_reg, col_next;
    logic [DIM_W-1:0]       row_reg, row_next;
    logic                   done_reg, done_next;
    logic [IDX_W-1:0]       wk_idx_reg, wk_idx_next;
    logic [IDX_W-1:0]       wk_left_reg, wk_left_next;
    logic [IDX_W-1:0]       wk_right_reg, wk_right_next;
    logic [SYM_W-1:0]       wk_sym_reg, wk_sym_next;
    logic [LEN_W-1:0]       len_reg, len_next;
    logic [CODE_W-1:0]      bits_reg, bits_next;
    logic [SYM_W-1:0]       ins_sym_reg, ins_sym_next;
    logic [IDX_W-1:0]       dnext_reg, dnext_next;
    logic                   miss_reg, miss_next;
    logic                   out_valid_reg, out_valid_next;
    pctpd_pkg::out_item_t   out_item_reg, out_item_next;

    logic [ENT_W-1:0]       mem [NODE_DEPTH];
    logic [ENT_W-1:0]       rd_data_reg;
    logic                   mem_we, mem_re;
    logic [IDX_W-1:0]       mem_waddr, mem_raddr;
    logic [ENT_W-1:0]       mem_wdata;

    logic [IDX_W-1:0]       rd_left, rd_right;
    logic [SYM_W-1:0]       rd_sym;
    logic [CMP_W-1:0]       w_ext, h_ext, max_ext;
    logic [DIM_W-1:0]       w_eff, h_eff;
    logic                   out_free, accept;
    logic                   wb_en;
    logic [IDX_W-1:0]       wb_left, wb_right;
    logic [SYM_W-1:0]       wb_sym;
    logic [BIT_W-1:0]       bit_idx;
    logic                   cur_bit;
    logic [IDX_W-1:0]       slot;
    logic                   store_full;
    logic [IDX_W-1:0]       base_left, base_right, dec_child;
    logic [DIM_W-1:0]       p_col, p_row;
    logic                   p_done, image_full;
    logic [DIM_W:0]         col_inc;

    assign {rd_left, rd_right, rd_sym} = rd_data_reg;

    assign max_ext = CMP_W'(MAX_DIMENSION);
    assign w_ext   = CMP_W'(width_reg);
    assign h_ext   = CMP_W'(height_reg);

    always_comb
    begin
        priority if (w_ext == '0)
        begin
            w_eff = DIM_W'(1);
        end
        else if (w_ext > max_ext)
        begin
            w_eff = DIM_W'(max_ext);
        end
        else
        begin
            w_eff = DIM_W'(w_ext);
        end
        priority if (h_ext == '0)
        begin
            h_eff = DIM_W'(1);
        end
        else if (h_ext > max_ext)
        begin
            h_eff = DIM_W'(max_ext);
        end
        else
        begin
            h_eff = DIM_W'(h_ext);
        end
    end

    assign in_stall   = (state_reg != ST_IDLE);
    assign accept     = in_valid && !in_stall;
    assign out_free   = !out_valid_reg || !out_stall;
    assign out_valid  = out_valid_reg;
    assign out_item   = out_item_reg;

    assign bit_idx    = BIT_W'(len_reg - 1'b1);
    assign cur_bit    = bits_reg[bit_idx];
    assign slot       = cur_bit ? wk_right_reg : wk_left_reg;
    assign store_full = (used_reg == USED_W'(NODE_DEPTH));
    assign base_left  = (cur_node_reg == '0) ? root_left_reg : cache_left_reg;
    assign base_right = (cur_node_reg == '0) ? root_right_reg : cache_right_reg;
    assign dec_child  = in_item.stream_bit ? base_right : base_left;

    // pixel position for a leaf reached now
    always_comb
    begin
        p_col  = col_reg;
        p_row  = row_reg;
        p_done = done_reg;
        if (!p_done && (p_col >= w_eff))
        begin
            if (({1'b0, p_row} + 1'b1) >= {1'b0, h_eff})
            begin
                p_done = 1'b1;
            end
            else
            begin
                p_row = p_row + 1'b1;
                p_col = '0;
            end
        end
        image_full = p_done || (p_row >= h_eff);
        col_inc    = {1'b0, p_col} + 1'b1;
    end

    always_comb
    begin
        state_next       = state_reg;
        root_left_next   = root_left_reg;
        root_right_next  = root_right_reg;
        root_sym_next    = root_sym_reg;
        cache_left_next  = cache_left_reg;
        cache_right_next = cache_right_reg;
        cur_node_next    = cur_node_reg;
        used_next        = used_reg;
        col_next         = col_reg;
        row_next         = row_reg;
        done_next        = done_reg;
        wk_idx_next      = wk_idx_reg;
        wk_left_next     = wk_left_reg;
        wk_right_next    = wk_right_reg;
        wk_sym_next      = wk_sym_reg;
        len_next         = len_reg;
        bits_next        = bits_reg;
        ins_sym_next     = ins_sym_reg;
        dnext_next       = dnext_reg;
        miss_next        = miss_reg;
        out_valid_next   = out_valid_reg && out_stall;
        out_item_next    = out_item_reg;
        mem_re           = 1'b0;
        mem_raddr        = '0;
        wb_en            = 1'b0;
        wb_left          = wk_left_reg;
        wb_right         = wk_right_reg;
        wb_sym           = wk_sym_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (in_item.kind)
                        pctpd_pkg::KIND_CLEAR:
                        begin
                            root_left_next  = '0;
                            root_right_next = '0;
                            root_sym_next   = '0;
                            used_next       = USED_W'(1);
                            cur_node_next   = '0;
                            col_next        = '0;
                            row_next        = '0;
                            done_next       = 1'b0;
                        end
                        pctpd_pkg::KIND_INSERT:
                        begin
                            wk_idx_next   = '0;
                            wk_left_next  = root_left_reg;
                            wk_right_next = root_right_reg;
                            wk_sym_next   = root_sym_reg;
                            bits_next     = in_item.code_bits;
                            ins_sym_next  = in_item.symbol;
                            if (in_item.code_length > LEN_W'(LEN_LIMIT))
                            begin
                                len_next = LEN_W'(LEN_LIMIT);
                            end
                            else
                            begin
                                len_next = in_item.code_length;
                            end
                            state_next = ST_INS_STEP;
                        end
                        pctpd_pkg::KIND_DECODE:
                        begin
                            dnext_next = dec_child;
                            miss_next  = (dec_child == '0);
                            mem_re     = (dec_child != '0);
                            mem_raddr  = dec_child;
                            state_next = ST_DEC_WAIT;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_INS_STEP:
            begin
                priority if (len_reg == '0)
                begin
                    wb_en      = 1'b1;
                    wb_sym     = ins_sym_reg;
                    state_next = ST_IDLE;
                end
                else if ((slot == '0) && store_full)
                begin
                    if (out_free)
                    begin
                        wb_en          = 1'b1;
                        out_valid_next = 1'b1;
                        out_item_next  = '{status: pctpd_pkg::STATUS_STORE_FULL,
                                           color_index: '0, row: '0, column: '0};
                        state_next     = ST_IDLE;
                    end
                end
                else if (slot == '0)
                begin
                    wb_en = 1'b1;
                    if (cur_bit)
                    begin
                        wb_right = used_reg[IDX_W-1:0];
                    end
                    else
                    begin
                        wb_left = used_reg[IDX_W-1:0];
                    end
                    wk_idx_next   = used_reg[IDX_W-1:0];
                    wk_left_next  = '0;
                    wk_right_next = '0;
                    wk_sym_next   = '0;
                    used_next     = used_reg + 1'b1;
                    len_next      = len_reg - 1'b1;
                end
                else
                begin
                    mem_re      = 1'b1;
                    mem_raddr   = slot;
                    wk_idx_next = slot;
                    len_next    = len_reg - 1'b1;
                    state_next  = ST_INS_WAIT;
                end
            end
            ST_INS_WAIT:
            begin
                wk_left_next  = rd_left;
                wk_right_next = rd_right;
                wk_sym_next   = rd_sym;
                state_next    = ST_INS_STEP;
            end
            ST_DEC_WAIT:
            begin
                priority if (miss_reg)
                begin
                    if (out_free)
                    begin
                        cur_node_next  = '0;
                        out_valid_next = 1'b1;
                        out_item_next  = '{status: pctpd_pkg::STATUS_MISSING,
                                           color_index: '0, row: '0, column: '0};
                        state_next     = ST_IDLE;
                    end
                end
                else if ((rd_left != '0) || (rd_right != '0))
                begin
                    cur_node_next    = dnext_reg;
                    cache_left_next  = rd_left;
                    cache_right_next = rd_right;
                    state_next       = ST_IDLE;
                end
                else if (out_free)
                begin
                    cur_node_next  = '0;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                    done_next      = p_done;
                    row_next       = p_row;
                    col_next       = p_col;
                    if (image_full)
                    begin
                        out_item_next = '{status: pctpd_pkg::STATUS_IMAGE_FULL,
                                          color_index: rd_sym, row: '0, column: '0};
                    end
                    else
                    begin
                        out_item_next = '{status: pctpd_pkg::STATUS_PIXEL,
                                          color_index: rd_sym,
                                          row: POS_W'(p_row),
                                          column: POS_W'(p_col)};
                        col_next = DIM_W'(col_inc);
                        if (col_inc >= {1'b0, w_eff})
                        begin
                            if (({1'b0, p_row} + 1'b1) >= {1'b0, h_eff})
                            begin
                                done_next = 1'b1;
                            end
                            else
                            begin
                                row_next = p_row + 1'b1;
                                col_next = '0;
                            end
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // write back the working node: root to flops, others to memory
        mem_we    = wb_en && (wk_idx_reg != '0);
        mem_waddr = wk_idx_reg;
        mem_wdata = {wb_left, wb_right, wb_sym};
        if (wb_en && (wk_idx_reg == '0))
        begin
            root_left_next  = wb_left;
            root_right_next = wb_right;
            root_sym_next   = wb_sym;
        end
        // forward a write of the node the decode walk rests on
        if (mem_we && (mem_waddr == cur_node_reg))
        begin
            cache_left_next  = wb_left;
            cache_right_next = wb_right;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            width_reg      <= pctpd_pkg::CFG_DIM_RESET;
            height_reg     <= pctpd_pkg::CFG_DIM_RESET;
            root_left_reg  <= '0;
            root_right_reg <= '0;
            root_sym_reg   <= '0;
            cur_node_reg   <= '0;
            used_reg       <= USED_W'(1);
            col_reg        <= '0;
            row_reg        <= '0;
            done_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            root_left_reg  <= root_left_next;
            root_right_reg <= root_right_next;
            root_sym_reg   <= root_sym_next;
            cur_node_reg   <= cur_node_next;
            used_reg       <= used_next;
            col_reg        <= col_next;
            row_reg        <= row_next;
            done_reg       <= done_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_we)
            begin
                if (cfg_index == pctpd_pkg::CFG_IMAGE_WIDTH)
                begin
                    width_reg <= cfg_data;
                end
                else
                begin
                    height_reg <= cfg_data;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cache_left_reg  <= cache_left_next;
        cache_right_reg <= cache_right_next;
        wk_idx_reg      <= wk_idx_next;
        wk_left_reg     <= wk_left_next;
        wk_right_reg    <= wk_right_next;
        wk_sym_reg      <= wk_sym_next;
        len_reg         <= len_next;
        bits_reg        <= bits_next;
        ins_sym_reg     <= ins_sym_next;
        dnext_reg       <= dnext_next;
        miss_reg        <= miss_next;
        out_item_reg    <= out_item_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[mem_raddr];
        end
    end

endmodule

@@ rtl/pctpd_checker.sv @@
// Port-level checker for the prefix-code tree pixel decoder, with its bind.
`include "prefix_code_tree_pixel_decoder_assert.svh"

module pctpd_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    input  logic                                in_stall,
    input  pctpd_pkg::in_item_t                 in_item,
    input  logic                                out_valid,
    input  logic                                out_stall,
    input  pctpd_pkg::out_item_t                out_item
);

    logic in_take;
    logic out_err;

    assign in_take = in_valid && !in_stall;
    assign out_err = out_valid && ((out_item.status == pctpd_pkg::STATUS_MISSING) ||
                                   (out_item.status == pctpd_pkg::STATUS_STORE_FULL));

    `PCTPD_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
        out_valid && $stable(out_item))
    `PCTPD_ASSERT_NEXT(a_decode_busy, in_take && (in_item.kind == pctpd_pkg::KIND_DECODE),
        in_stall)
    `PCTPD_ASSERT_NEXT(a_clear_quick, in_take && (in_item.kind == pctpd_pkg::KIND_CLEAR),
        !in_stall)
    `PCTPD_ASSERT_NOW(a_error_blank, out_err,
        (out_item.color_index == '0) && (out_item.row == '0) && (out_item.column == '0))

endmodule

bind prefix_code_tree_pixel_decoder pctpd_checker u_pctpd_checker (.*);
